FILE: rtl/mft_pkg.sv
`timescale 1ns / 1ps
package mft_pkg;

    localparam int unsigned DefEntries     = 64;
    localparam int unsigned DefIgnoreSlots = 4;
    localparam int unsigned IgnoreRegs     = 4;

    localparam logic [1:0] CMD_PACKET = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_CHANGE = 2'd3;

    localparam logic [2:0] VER_UNKNOWN = 3'd0;
    localparam logic [2:0] VER_1_0     = 3'd1;
    localparam logic [2:0] VER_1_3     = 3'd4;

    localparam logic [2:0] CFG_IGN_COUNT = 3'd0;
    localparam logic [2:0] CFG_IGN_TYPE0 = 3'd1;
    localparam logic [2:0] CFG_IGN_TYPE3 = 3'd4;

    localparam logic [3:0] V_FORWARD         = 4'd0;
    localparam logic [3:0] V_IGNORED         = 4'd1;
    localparam logic [3:0] V_BROADCAST       = 4'd2;
    localparam logic [3:0] V_UNKNOWN         = 4'd3;
    localparam logic [3:0] V_VER_UNKNOWN     = 4'd4;
    localparam logic [3:0] V_VER_UNSUPPORTED = 4'd5;
    localparam logic [3:0] V_INSERTED        = 4'd6;
    localparam logic [3:0] V_MODIFIED        = 4'd7;
    localparam logic [3:0] V_REMOVED         = 4'd8;
    localparam logic [3:0] V_ABSENT          = 4'd9;
    localparam logic [3:0] V_FULL            = 4'd10;

    localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

    // controller -> datapath
    typedef struct packed {
        logic load;    // latch item, start table scan
        logic finish;  // resolve verdict, update table, load output
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic out_busy;
    } t_sts;

endpackage

FILE: rtl/mft_ctrl.sv
`timescale 1ns / 1ps
module mft_ctrl
    import mft_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_ctl o_ctl
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_ready      = (r_state == S_IDLE);
    assign o_ctl.load   = (r_state == S_IDLE) && i_valid;
    assign o_ctl.finish = (r_state == S_DONE) && !i_sts.out_busy;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_SCAN;
            S_SCAN: if (i_sts.scan_done) n_state = S_DONE;
            S_DONE: if (!i_sts.out_busy) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/mft_datapath.sv
`timescale 1ns / 1ps
module mft_datapath
    import mft_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = DefEntries,
    parameter int unsigned IGNORE_SLOTS  = DefIgnoreSlots
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctl        i_ctl,
    output t_sts        o_sts,
    input  logic [1:0]  i_cmd,
    input  logic [47:0] i_mac,
    input  logic [15:0] i_ethertype,
    input  logic [2:0]  i_of_version,
    input  logic [63:0] i_switch_id,
    input  logic [31:0] i_port_number,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_verdict,
    output logic [63:0] o_out_switch_id,
    output logic [31:0] o_out_port
);

    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // latched item
    logic [1:0]  r_cmd;
    logic [47:0] r_mac;
    logic [15:0] r_et;
    logic [2:0]  r_ver;
    logic [63:0] r_sw;
    logic [31:0] r_port;

    // config
    logic [2:0]  r_ign_cnt;
    logic [15:0] r_ign_type [IgnoreRegs];

    // table
    logic [47:0] mem_mac  [TABLE_ENTRIES];
    logic [63:0] mem_sw   [TABLE_ENTRIES];
    logic [31:0] mem_port [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;

    // scan pipeline
    logic          r_scan;
    logic [AW:0]   r_addr;
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_idx;
    logic [47:0]   r_q_mac;
    logic [63:0]   r_q_sw;
    logic [31:0]   r_q_port;
    logic          r_q_valid;
    logic          r_hit;
    logic [AW-1:0] r_hit_idx;
    logic [63:0]   r_hit_sw;
    logic [31:0]   r_hit_port;
    logic          r_free;
    logic [AW-1:0] r_free_idx;

    // output register
    logic        r_out_vld;
    logic [3:0]  r_verdict;
    logic [63:0] r_osw;
    logic [31:0] r_oport;

    logic          issue;
    logic          ignored;
    logic [2:0]    ign_n;
    logic [3:0]    n_verdict;
    logic          we_data;
    logic          we_key;
    logic          set_valid;
    logic          clr_valid;
    logic [AW-1:0] wa;

    assign issue = r_scan && !r_hit && (r_addr < (AW+1)'(TABLE_ENTRIES));

    assign o_sts.scan_done = r_scan && !issue && !r_rd_vld;
    assign o_sts.out_busy  = r_out_vld && !i_ready;

    always_comb begin
        ign_n   = (r_ign_cnt > 3'(IGNORE_SLOTS)) ? 3'(IGNORE_SLOTS) : r_ign_cnt;
        ignored = 1'b0;
        for (int i = 0; i < IGNORE_SLOTS; i++) begin
            if ((3'(i) < ign_n) && (r_ign_type[i] == r_et)) ignored = 1'b1;
        end
    end

    always_comb begin
        n_verdict = V_FULL;
        we_data   = 1'b0;
        we_key    = 1'b0;
        set_valid = 1'b0;
        clr_valid = 1'b0;
        wa        = r_hit ? r_hit_idx : r_free_idx;
        unique case (r_cmd)
            CMD_PACKET: begin
                if (ignored)                 n_verdict = V_IGNORED;
                else if (r_mac == BCAST_MAC) n_verdict = V_BROADCAST;
                else if (!r_hit)             n_verdict = V_UNKNOWN;
                else if (r_ver == VER_UNKNOWN) n_verdict = V_VER_UNKNOWN;
                else if (r_ver == VER_1_0 || r_ver == VER_1_3) n_verdict = V_FORWARD;
                else                         n_verdict = V_VER_UNSUPPORTED;
            end
            CMD_REMOVE: begin
                n_verdict = r_hit ? V_REMOVED : V_ABSENT;
                clr_valid = r_hit;
            end
            default: begin
                if (r_hit) begin
                    n_verdict = V_MODIFIED;
                    we_data   = 1'b1;
                end else if (r_free) begin
                    n_verdict = V_INSERTED;
                    we_data   = 1'b1;
                    we_key    = 1'b1;
                    set_valid = 1'b1;
                end
            end
        endcase
    end

    // table memories: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.finish && we_data) begin
            mem_sw[wa]   <= r_sw;
            mem_port[wa] <= r_port;
        end
        if (i_ctl.finish && we_key) begin
            mem_mac[wa] <= r_mac;
        end
        if (issue) begin
            r_q_mac  <= mem_mac[r_addr[AW-1:0]];
            r_q_sw   <= mem_sw[r_addr[AW-1:0]];
            r_q_port <= mem_port[r_addr[AW-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= i_cmd;
            r_mac  <= i_mac;
            r_et   <= i_ethertype;
            r_ver  <= i_of_version;
            r_sw   <= i_switch_id;
            r_port <= i_port_number;
        end
        if (issue) begin
            r_rd_idx  <= r_addr[AW-1:0];
            r_q_valid <= r_valid[r_addr[AW-1:0]];
        end
        if (r_rd_vld && !r_hit && r_q_valid && (r_q_mac == r_mac)) begin
            r_hit_idx  <= r_rd_idx;
            r_hit_sw   <= r_q_sw;
            r_hit_port <= r_q_port;
        end
        if (r_rd_vld && !r_free && !r_q_valid) begin
            r_free_idx <= r_rd_idx;
        end
        if (i_ctl.finish) begin
            r_verdict <= n_verdict;
            r_osw     <= (n_verdict == V_FORWARD) ? r_hit_sw : 64'd0;
            r_oport   <= (n_verdict == V_FORWARD) ? r_hit_port : 32'd0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan    <= 1'b0;
            r_addr    <= '0;
            r_rd_vld  <= 1'b0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            r_valid   <= '0;
            r_out_vld <= 1'b0;
            r_ign_cnt <= '0;
            for (int i = 0; i < IgnoreRegs; i++) r_ign_type[i] <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_IGN_COUNT) begin
                    r_ign_cnt <= i_cfg_data[2:0];
                end else if (i_cfg_index <= CFG_IGN_TYPE3) begin
                    r_ign_type[2'(i_cfg_index - CFG_IGN_TYPE0)] <= i_cfg_data;
                end
            end
            r_rd_vld <= issue;
            if (issue) r_addr <= r_addr + (AW+1)'(1);
            if (r_rd_vld && !r_hit && r_q_valid && (r_q_mac == r_mac)) r_hit <= 1'b1;
            if (r_rd_vld && !r_free && !r_q_valid) r_free <= 1'b1;
            if (i_ctl.load) begin
                r_scan <= 1'b1;
                r_addr <= '0;
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end
            if (i_ctl.finish) begin
                r_scan <= 1'b0;
                if (set_valid) r_valid[wa] <= 1'b1;
                if (clr_valid) r_valid[wa] <= 1'b0;
            end
            if (i_ctl.finish)     r_out_vld <= 1'b1;
            else if (i_ready)     r_out_vld <= 1'b0;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_verdict       = r_verdict;
    assign o_out_switch_id = r_osw;
    assign o_out_port      = r_oport;

endmodule

FILE: rtl/mac_forwarding_table.sv
`timescale 1ns / 1ps
// Layer-2 MAC forwarding table.
// Input channel (i_valid/o_ready): one item per packet lookup or device event.
//   Packets are checked against the ignore ethertype list, then broadcast,
//   then looked up; device events insert, modify or remove a table entry.
// Output channel (o_valid/i_ready): exactly one verdict item per input item,
//   with switch id and port filled only on a forward verdict.
// Config port (i_cfg_we/i_cfg_index/i_cfg_data): write-only registers,
//   index 0 ignore count, 1..4 ignored ethertypes; write only when idle.
// Timing: the table is scanned one entry a cycle through a registered read
//   port, stopping early on a hit. One item is processed at a time and the
//   next can be accepted in the cycle after the result is loaded.
// Reset (synchronous, active low) clears all valid bits, the config
//   registers and the control state; entry contents are not cleared.
// Stall: the result sits in an output register; the next item is accepted
//   while it waits, but its own result is held back until the register is
//   taken, and no further item is accepted meanwhile.
module mac_forwarding_table
    import mft_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = DefEntries,
    parameter int unsigned IGNORE_SLOTS  = DefIgnoreSlots
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [47:0] i_mac,
    input  logic [15:0] i_ethertype,
    input  logic [2:0]  i_of_version,
    input  logic [63:0] i_switch_id,
    input  logic [31:0] i_port_number,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_verdict,
    output logic [63:0] o_out_switch_id,
    output logic [31:0] o_out_port,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_ctl ctl;
    t_sts sts;

    // sequencer: idle -> scan -> resolve
    mft_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    // table memories, scan pipeline, verdict logic and output register
    mft_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IGNORE_SLOTS  (IGNORE_SLOTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_sts           (sts),
        .i_cmd           (i_cmd),
        .i_mac           (i_mac),
        .i_ethertype     (i_ethertype),
        .i_of_version    (i_of_version),
        .i_switch_id     (i_switch_id),
        .i_port_number   (i_port_number),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_verdict       (o_verdict),
        .o_out_switch_id (o_out_switch_id),
        .o_out_port      (o_out_port)
    );

endmodule
